FILE: src/ifd_pkg.sv
package ifd_pkg;

  // Frame layout
  localparam int unsigned FRAME_BYTES = 11;
  localparam int unsigned POS_W       = 4;
  localparam logic [POS_W-1:0] POS_HUNT = 4'd0;
  localparam logic [POS_W-1:0] POS_CSUM = 4'(FRAME_BYTES - 1);

  localparam logic [7:0] HEADER_RESET = 8'h55;

  // Kind byte codes as they arrive on the line
  localparam logic [7:0] KB_ACCEL = 8'h51;
  localparam logic [7:0] KB_GYRO  = 8'h52;
  localparam logic [7:0] KB_ANGLE = 8'h53;
  localparam logic [7:0] KB_MAG   = 8'h54;
  localparam logic [7:0] KB_REG   = 8'h5F;

  typedef enum logic [2:0] {
    KIND_ACCEL = 3'd0,
    KIND_GYRO  = 3'd1,
    KIND_ANGLE = 3'd2,
    KIND_MAG   = 3'd3,
    KIND_REG   = 3'd4,
    KIND_OTHER = 3'd5
  } frame_kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_CSUM_ERR  = 2'd1,
    STAT_BAD_KIND  = 2'd2
  } frame_status_t;

  // Result sideband: kind in the low bits, status above, zero pad to a byte
  typedef struct packed {
    logic [2:0]    pad;
    frame_status_t status;
    frame_kind_t   kind;
  } out_user_t;

  function automatic frame_kind_t kind_of(input logic [7:0] kb);
    frame_kind_t k;
    unique case (kb)
      KB_ACCEL: k = KIND_ACCEL;
      KB_GYRO:  k = KIND_GYRO;
      KB_ANGLE: k = KIND_ANGLE;
      KB_MAG:   k = KIND_MAG;
      KB_REG:   k = KIND_REG;
      default:  k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

FILE: src/imu_frame_decoder_top.sv
// Channel  | Dir | Payload                                       | Transfer
// in_      | in  | tdata[7:0] rx_data                            | in_tvalid & in_tready
// out_     | out | tdata 64b four words, tuser kind/status       | out_tvalid & out_tready
// cfg_     | in  | cfg_data[7:0] header_byte                     | cfg_valid & cfg_ready
//
// One byte is taken per cycle; the checksum byte yields a result in the next cycle.
// The only stall is on the checksum byte while the result register still holds a
// result that has not been taken; all other bytes are taken regardless.
// cfg_ready is always high. Reset (rst_n low, synchronous) returns to header hunt
// with header_byte 0x55 and drops any pending result.
module imu_frame_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] axis_x, [31:16] axis_y, [47:32] axis_z,
                                  // [63:48] extra_word
  output logic [7:0]  out_tuser,  // [2:0] frame_kind, [4:3] frame_status, [7:5] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import ifd_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       hdr_r;
  logic [7:0]       store_r [1:9];
  logic             out_valid_r;
  logic [63:0]      out_data_r;
  out_user_t        out_user_r, out_user_nxt;

  logic in_xfer;
  logic at_csum;
  logic hunting;

  assign hunting   = (pos_r == POS_HUNT);
  assign at_csum   = (pos_r >= POS_CSUM);
  assign cfg_ready = 1'b1;
  // only the checksum byte needs a free result slot
  assign in_tready = !at_csum || !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // Advance position and running sum
  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (in_xfer) begin
      if (hunting) begin
        if (in_tdata == hdr_r) begin
          pos_nxt = 4'd1;
          sum_nxt = in_tdata;
        end
      end else if (at_csum) begin
        pos_nxt = POS_HUNT;
        sum_nxt = 8'd0;
      end else begin
        pos_nxt = pos_r + 4'd1;
        sum_nxt = sum_r + in_tdata;
      end
    end
  end

  // Decode the closing frame
  always_comb begin
    out_user_nxt        = '0;
    out_user_nxt.kind   = kind_of(store_r[1]);
    if (in_tdata != sum_r) begin
      out_user_nxt.status = STAT_CSUM_ERR;
    end else if (out_user_nxt.kind == KIND_OTHER) begin
      out_user_nxt.status = STAT_BAD_KIND;
    end else begin
      out_user_nxt.status = STAT_OK;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_HUNT;
      sum_r       <= 8'd0;
      hdr_r       <= HEADER_RESET;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      if (cfg_valid && cfg_ready) begin
        hdr_r <= cfg_data;
      end
      if (in_xfer && at_csum) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold frame bytes 1 to 9; byte 0 only feeds the sum
  for (genvar i = 1; i <= 9; i++) begin : g_store
    always_ff @(posedge clk) begin
      if (in_xfer && (pos_r == 4'(i))) begin
        store_r[i] <= in_tdata;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (in_xfer && at_csum) begin
      out_user_r <= out_user_nxt;
      out_data_r <= {store_r[9], store_r[8], store_r[7], store_r[6],
                     store_r[5], store_r[4], store_r[3], store_r[2]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: src/ifd_checker.sv
module ifd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [7:0]  out_tuser
);
  import ifd_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result dropped or changed");

  // A new result follows an input transfer
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result without input transfer");

  // Unknown kind reports bad kind unless the checksum failed
  a_kind_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[4:3] != STAT_CSUM_ERR) |->
      ((out_tuser[2:0] == KIND_OTHER) == (out_tuser[4:3] == STAT_BAD_KIND)))
    else $error("kind and status disagree");

  // Status, kind and pad stay within their codes
  a_user_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[4:3] != 2'd3) && (out_tuser[7:5] == 3'd0)
                   && (out_tuser[2:1] != 2'd3))
    else $error("sideband code out of range");

endmodule

bind imu_frame_decoder_top ifd_checker u_ifd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
